@@ design/poi_pkg.sv @@
package poi_pkg;

    localparam int CordicSteps = 24;
    localparam int CordicIdxW  = 5;
    localparam logic [CordicIdxW-1:0] CordicLast = CordicIdxW'(CordicSteps - 1);

    localparam logic signed [33:0] GainQ30   = 34'sd652032875;
    localparam logic signed [33:0] OneQ30    = 34'sd1073741824;
    localparam logic [21:0]        RadToBam  = 22'd2670177;

    localparam logic [1:0] RegStartX       = 2'd0;
    localparam logic [1:0] RegStartY       = 2'd1;
    localparam logic [1:0] RegStartHeading = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [23:0] vel_forward;
        logic [23:0] vel_lateral;
        logic [23:0] yaw_rate;
        logic [15:0] elapsed;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [31:0] pose_heading;
        logic [31:0] quat_z;
        logic [31:0] quat_w;
        logic        saturated;
    } t_out_word;

    function automatic logic [31:0] atan_bam(input logic [CordicIdxW-1:0] k);
        logic [31:0] r;
        case (k)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/poi_in_if.sv @@
interface poi_in_if;
    logic              valid;
    logic              ready;
    poi_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/poi_out_if.sv @@
interface poi_out_if;
    logic               valid;
    logic               ready;
    poi_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/planar_odometry_integrator.sv @@
// Dead-reckoning pose integrator. One word at a time: an integrate word goes
// through two CORDIC runs and eight bit-serial multiplies from acceptance to
// result, done one after another on one shared CORDIC and one shared
// multiplier; a reload word goes through one CORDIC run. The result waits
// in an output register; the next word may be taken meanwhile, but its result
// is held until the register has been handed off.
// Positions saturate, heading wraps, quat is sin/cos of half the new heading.
module planar_odometry_integrator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    poi_in_if.sink      i_in,
    poi_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [3:0] {
        S_IDLE, S_CS, S_CW, S_M1, S_M2, S_M3, S_M4, S_MX, S_MY, S_MH,
        S_UPD, S_QS, S_QW, S_OUT
    } t_state;

    t_state             r_state;
    logic [31:0]        r_sx, r_sy, r_sh;
    logic [31:0]        r_ax, r_ay, r_ah;
    poi_pkg::t_in_word  r_in;
    logic signed [31:0] r_s, r_c;
    logic signed [79:0] r_p;
    logic signed [47:0] r_tx, r_ty;
    logic               r_clip, r_ovalid;
    poi_pkg::t_out_word r_out;
    // sub-phase within multi-multiply states
    logic [1:0]         r_ph;

    logic               n_cstart, n_mstart;
    logic [31:0]        n_cang;
    logic signed [47:0] n_ma;
    logic signed [31:0] n_mb;
    logic               w_cdone, w_mdone;
    logic [31:0]        w_sin, w_cos;
    logic signed [79:0] w_prod;

    poi_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_cstart), .i_angle(n_cang),
        .o_done(w_cdone), .o_sin(w_sin), .o_cos(w_cos)
    );
    poi_serial_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_mstart), .i_a(n_ma),
        .i_b(n_mb), .o_done(w_mdone), .o_prod(w_prod)
    );

    // round half away from zero by s bits
    function automatic logic signed [79:0] rnd(input logic signed [79:0] v, input int s);
        logic [79:0] mag;
        logic [79:0] r;
        mag = v[79] ? 80'(-v) : 80'(v);
        r   = (mag + (80'd1 << (s - 1))) >> s;
        return v[79] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [31:0] sat(input logic [31:0] a, input logic signed [79:0] d,
                                        output logic c);
        logic signed [80:0] t;
        t = 81'(signed'(a)) + 81'(d);
        c = 1'b0;
        if (t > 81'sd2147483647) begin
            c = 1'b1;
            return 32'h7fffffff;
        end
        if (t < -81'sd2147483648) begin
            c = 1'b1;
            return 32'h80000000;
        end
        return t[31:0];
    endfunction

    logic        w_in_acc;
    logic        w_cx, w_cy;
    logic [31:0] w_nx, w_ny;
    logic signed [79:0] w_dh;
    logic signed [79:0] w_txr, w_tyr;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;
    assign pready      = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            poi_pkg::RegStartX:       prdata = r_sx;
            poi_pkg::RegStartY:       prdata = r_sy;
            poi_pkg::RegStartHeading: prdata = r_sh;
            default:                  prdata = '0;
        endcase
    end

    // multiplier is launched only in the first sub-phase of each state
    always_comb begin
        n_cstart = 1'b0;
        n_cang   = r_ah;
        n_mstart = 1'b0;
        n_ma     = '0;
        n_mb     = '0;
        case (r_state)
            S_CS: n_cstart = 1'b1;
            S_QS: begin
                n_cstart = 1'b1;
                n_cang   = {1'b0, r_ah[31:1]};
            end
            S_M1: begin
                n_mstart = (r_ph == 2'd0);
                n_ma = 48'(signed'(r_in.vel_forward));
                n_mb = r_c;
            end
            S_M2: begin
                n_mstart = (r_ph == 2'd0);
                n_ma = 48'(signed'(r_in.vel_lateral));
                n_mb = r_s;
            end
            S_M3: begin
                n_mstart = (r_ph == 2'd0);
                n_ma = 48'(signed'(r_in.vel_forward));
                n_mb = r_s;
            end
            S_M4: begin
                n_mstart = (r_ph == 2'd0);
                n_ma = 48'(signed'(r_in.vel_lateral));
                n_mb = r_c;
            end
            S_MX: begin
                n_mstart = (r_ph == 2'd0);
                n_ma = r_tx;
                n_mb = {16'd0, r_in.elapsed};
            end
            S_MY: begin
                n_mstart = (r_ph == 2'd0);
                n_ma = r_ty;
                n_mb = {16'd0, r_in.elapsed};
            end
            S_MH: begin
                n_mstart = (r_ph == 2'd0);
                n_ma = 48'(signed'(r_in.yaw_rate));
                n_mb = {16'd0, r_in.elapsed};
            end
            S_UPD: begin
                n_mstart = (r_ph == 2'd0);
                n_ma = r_p[47:0];
                n_mb = {10'd0, poi_pkg::RadToBam};
            end
            default: ;
        endcase
        w_nx  = sat(r_ax, rnd(r_p, 16), w_cx);
        w_ny  = sat(r_ay, rnd(w_prod, 16), w_cy);
        w_dh  = rnd(w_prod, 24);
        w_txr = rnd(r_p - w_prod, 30);
        w_tyr = rnd(r_p + w_prod, 30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sx     <= 32'd524288;
            r_sy     <= 32'hfffe0000;
            r_sh     <= '0;
            r_ax     <= 32'd524288;
            r_ay     <= 32'hfffe0000;
            r_ah     <= '0;
            r_ph     <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    poi_pkg::RegStartX:       r_sx <= pwdata;
                    poi_pkg::RegStartY:       r_sy <= pwdata;
                    poi_pkg::RegStartHeading: r_sh <= pwdata;
                    default: ;
                endcase
            end
            // a handoff in S_OUT is followed by the reload of the register
            if (o_out.valid && o_out.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_in_acc) begin
                    r_in   <= i_in.data;
                    r_clip <= 1'b0;
                    if (i_in.data.mode) begin
                        r_ax    <= r_sx;
                        r_ay    <= r_sy;
                        r_ah    <= r_sh;
                        r_state <= S_QS;
                    end else begin
                        r_state <= S_CS;
                    end
                end
                S_CS: r_state <= S_CW;
                S_CW: if (w_cdone) begin
                    r_s <= w_sin;
                    r_c <= w_cos;
                    r_ph <= '0;
                    r_state <= S_M1;
                end
                // M1 -> wait -> M2 -> wait, etc; r_ph: 0 launch, 1 wait
                S_M1, S_M2, S_M3, S_M4, S_MX, S_MY, S_MH: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (w_mdone) begin
                        r_ph <= 2'd0;
                        case (r_state)
                            S_M1: begin r_p <= w_prod; r_state <= S_M2; end
                            S_M2: begin
                                r_tx    <= w_txr[47:0];
                                r_state <= S_M3;
                            end
                            S_M3: begin r_p <= w_prod; r_state <= S_M4; end
                            S_M4: begin
                                r_ty    <= w_tyr[47:0];
                                r_state <= S_MX;
                            end
                            S_MX: begin r_p <= w_prod; r_state <= S_MY; end
                            S_MY: begin
                                r_ax    <= w_nx;
                                r_ay    <= w_ny;
                                r_clip  <= w_cx | w_cy;
                                r_state <= S_MH;
                            end
                            default: begin r_p <= w_prod; r_state <= S_UPD; end
                        endcase
                    end
                end
                S_UPD: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (w_mdone) begin
                        r_ph    <= 2'd0;
                        r_ah    <= r_ah + w_dh[31:0];
                        r_state <= S_QS;
                    end
                end
                S_QS: r_state <= S_QW;
                S_QW: if (w_cdone) r_state <= S_OUT;
                // CORDIC outputs hold until its next start
                S_OUT: if (!r_ovalid || o_out.ready) begin
                    r_out.pose_x       <= r_ax;
                    r_out.pose_y       <= r_ay;
                    r_out.pose_heading <= r_ah;
                    r_out.quat_z       <= w_sin;
                    r_out.quat_w       <= w_cos;
                    r_out.saturated    <= r_clip;
                    r_ovalid           <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/poi_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module poi_cordic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_angle,
    output logic        o_done,
    output logic [31:0] o_sin,
    output logic [31:0] o_cos
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state                           r_state;
    logic signed [33:0]               r_x, r_y, r_z;
    logic                             r_flip;
    logic [poi_pkg::CordicIdxW-1:0]   r_k;
    logic                             r_done;
    logic [31:0]                      r_sin, r_cos;

    logic signed [33:0] w_z0, w_xs, w_ys, w_at, w_xf, w_yf, w_sc, w_cc;
    logic               w_fl;

    always_comb begin
        w_z0 = {{2{i_angle[31]}}, i_angle};
        w_fl = 1'b0;
        if (w_z0 > 34'sd1073741824) begin
            w_z0 = w_z0 - 34'sd2147483648;
            w_fl = 1'b1;
        end else if (w_z0 < -34'sd1073741824) begin
            w_z0 = w_z0 + 34'sd2147483648;
            w_fl = 1'b1;
        end
        w_xs = r_x >>> r_k;
        w_ys = r_y >>> r_k;
        w_at = {2'b00, poi_pkg::atan_bam(r_k)};
        w_xf = r_flip ? -r_x : r_x;
        w_yf = r_flip ? -r_y : r_y;
        w_sc = w_yf > poi_pkg::OneQ30 ? poi_pkg::OneQ30 :
               (w_yf < -poi_pkg::OneQ30 ? -poi_pkg::OneQ30 : w_yf);
        w_cc = w_xf > poi_pkg::OneQ30 ? poi_pkg::OneQ30 :
               (w_xf < -poi_pkg::OneQ30 ? -poi_pkg::OneQ30 : w_xf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_x     <= poi_pkg::GainQ30;
                    r_y     <= '0;
                    r_z     <= w_z0;
                    r_flip  <= w_fl;
                    r_k     <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                    if (r_k == poi_pkg::CordicLast) r_state <= S_FIN;
                    r_k <= r_k + 1'b1;
                end
                S_FIN: begin
                    r_sin   <= w_sc[31:0];
                    r_cos   <= w_cc[31:0];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;
endmodule

@@ design/poi_serial_mul.sv @@
// Shift-add signed multiplier: one multiplier bit per cycle.
// Product = a * b, a signed 48 bits, b signed 32 bits.
module poi_serial_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [47:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [79:0] o_prod
);
    logic               r_busy, r_done;
    logic [5:0]         r_cnt;
    logic signed [79:0] r_acc;
    logic signed [79:0] r_a;
    logic [31:0]        r_b;

    logic signed [79:0] w_term;
    always_comb begin
        w_term = r_b[0] ? r_a : 80'sd0;
        if (r_cnt == 6'd31) w_term = -w_term;   // sign bit weight is negative
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= {{32{i_a[47]}}, i_a};
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= r_acc + w_term;
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc + w_term;
endmodule

@@ tb/sv/planar_odometry_integrator_tb.sv @@
module planar_odometry_integrator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    poi_in_if  in_ch ();
    poi_out_if out_ch ();

    planar_odometry_integrator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic signed [31:0] cfg_x;
    logic signed [31:0] cfg_y;
    logic [31:0]        cfg_heading;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        pose_heading;

    poi_pkg::t_out_word pending_poses[$];
    int        error_count;
    int        words_sent;
    int        poses_checked;
    int        reloads_sent;
    int        clip_count;
    bit        hold_off;
    bit        allow_stall;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout at %0t", $realtime);
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > longint'(poi_pkg::OneQ30)) return longint'(poi_pkg::OneQ30);
        if (v < -longint'(poi_pkg::OneQ30)) return -longint'(poi_pkg::OneQ30);
        return v;
    endfunction

    // rotation-mode CORDIC on a binary angle
    task automatic cordic_sincos(input logic [31:0] ang, output longint s_o,
                                 output longint c_o);
        longint z;
        longint cx;
        longint cy;
        longint nx;
        bit     flip;
        longint tab[32];
        tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                81, 41, 20, 10, 5, 3, 1, 1, 0};
        z = longint'($signed(ang));
        cx = longint'(poi_pkg::GainQ30);
        cy = 0;
        flip = 1'b0;
        if (z > (longint'(1) <<< 30)) begin
            z -= longint'(1) <<< 31;
            flip = 1'b1;
        end else if (z < -(longint'(1) <<< 30)) begin
            z += longint'(1) <<< 31;
            flip = 1'b1;
        end
        for (int i = 0; i < poi_pkg::CordicSteps; i++) begin
            if (z >= 0) begin
                nx = cx - fshift(cy, i);
                cy = cy + fshift(cx, i);
                z -= tab[i];
            end else begin
                nx = cx + fshift(cy, i);
                cy = cy - fshift(cx, i);
                z += tab[i];
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        s_o = clamp_unit(cy);
        c_o = clamp_unit(cx);
    endtask

    function automatic logic signed [31:0] add_clip(logic signed [31:0] a, longint d,
                                                    ref bit clip);
        longint r;
        r = longint'(a) + d;
        if (r > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (r < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return r[31:0];
    endfunction

    task automatic predict_pose(input poi_pkg::t_in_word w);
        poi_pkg::t_out_word exp_pose;
        bit        clip;
        longint    sn;
        longint    cs;
        longint    qz;
        longint    qw;
        longint    vf;
        longint    vl;
        longint    wr;
        longint    dt;
        longint    tx;
        longint    ty;
        longint    dh;
        clip = 1'b0;
        if (w.mode) begin
            pose_x = cfg_x;
            pose_y = cfg_y;
            pose_heading = cfg_heading;
        end else begin
            vf = longint'($signed(w.vel_forward));
            vl = longint'($signed(w.vel_lateral));
            wr = longint'($signed(w.yaw_rate));
            dt = longint'(w.elapsed);
            cordic_sincos(pose_heading, sn, cs);
            tx = rshift(vf * cs - vl * sn, 30);
            ty = rshift(vf * sn + vl * cs, 30);
            pose_x = add_clip(pose_x, rshift(tx * dt, 16), clip);
            pose_y = add_clip(pose_y, rshift(ty * dt, 16), clip);
            dh = rshift(wr * dt * longint'(poi_pkg::RadToBam), 24);
            pose_heading = pose_heading + dh[31:0];
        end
        cordic_sincos(pose_heading >> 1, qz, qw);
        exp_pose.pose_x = pose_x;
        exp_pose.pose_y = pose_y;
        exp_pose.pose_heading = pose_heading;
        exp_pose.quat_z = qz[31:0];
        exp_pose.quat_w = qw[31:0];
        exp_pose.saturated = clip;
        if (clip) clip_count++;
        pending_poses.push_back(exp_pose);
    endtask

    // checker: one pose word per handshake
    initial begin
        poi_pkg::t_out_word got;
        poi_pkg::t_out_word want;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (pending_poses.size() == 0) begin
                    $display("%0t: unexpected word %h", $realtime, got);
                    error_count++;
                end else begin
                    want = pending_poses.pop_front();
                    poses_checked++;
                    if (got.pose_x !== want.pose_x) begin
                        $display("%0t: pose_x exp %h got %h", $realtime, want.pose_x,
                                 got.pose_x);
                        error_count++;
                    end
                    if (got.pose_y !== want.pose_y) begin
                        $display("%0t: pose_y exp %h got %h", $realtime, want.pose_y,
                                 got.pose_y);
                        error_count++;
                    end
                    if (got.pose_heading !== want.pose_heading) begin
                        $display("%0t: heading exp %h got %h", $realtime,
                                 want.pose_heading, got.pose_heading);
                        error_count++;
                    end
                    if (got.quat_z !== want.quat_z) begin
                        $display("%0t: quat_z exp %h got %h", $realtime, want.quat_z,
                                 got.quat_z);
                        error_count++;
                    end
                    if (got.quat_w !== want.quat_w) begin
                        $display("%0t: quat_w exp %h got %h", $realtime, want.quat_w,
                                 got.quat_w);
                        error_count++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $display("%0t: saturated exp %b got %b", $realtime,
                                 want.saturated, got.saturated);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver: random stall per word, or a long hold-off on request
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                for (int i = 0; i < 3000; i++) @(negedge i_clk);
                hold_off = 1'b0;
            end
            gap = allow_stall ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // always entered at a falling edge
    task automatic send_word(input poi_pkg::t_in_word w);
        int gap;
        gap = allow_stall ? $urandom_range(0, 19) : 0;
        repeat (gap) @(negedge i_clk);
        in_ch.data = w;
        in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_pose(w);
        words_sent++;
        if (w.mode) reloads_sent++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            poi_pkg::RegStartX:       cfg_x = val;
            poi_pkg::RegStartY:       cfg_y = val;
            poi_pkg::RegStartHeading: cfg_heading = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_poses();
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic poi_pkg::t_in_word make_step(logic [23:0] vf, logic [23:0] vl,
                                                    logic [23:0] wr, logic [15:0] dt);
        poi_pkg::t_in_word w;
        w.mode = 1'b0;
        w.vel_forward = vf;
        w.vel_lateral = vl;
        w.yaw_rate = wr;
        w.elapsed = dt;
        return w;
    endfunction

    function automatic poi_pkg::t_in_word random_word();
        poi_pkg::t_in_word w;
        int pick;
        w = make_step(24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 4) w.mode = 1'b1;
        else if (pick < 60) begin
            // realistic small-range motion keeps positions off the rails
            w.vel_forward = $signed(24'($urandom_range(0, 262144))) - 24'sd131072;
            w.vel_lateral = $signed(24'($urandom_range(0, 65536))) - 24'sd32768;
            w.elapsed = 16'($urandom_range(0, 2000));
        end else if (pick < 70) begin
            w.elapsed = 16'hffff;
        end
        return w;
    endfunction

    task automatic test_reset_pose();
        send_word(make_step(24'd0, 24'd0, 24'd0, 16'd0));
        send_word(make_step(24'd65536, 24'd0, 24'd0, 16'd32768));
        drain_poses();
    endtask

    task automatic test_directed_extremes();
        write_reg(poi_pkg::RegStartX, 32'h7fff0000);
        write_reg(poi_pkg::RegStartY, 32'h80010000);
        write_reg(poi_pkg::RegStartHeading, 32'h40000000);
        send_word('{mode: 1'b1, default: '0});
        send_word(make_step(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'hffff));
        send_word(make_step(24'h800000, 24'h800000, 24'h800000, 16'hffff));
        send_word(make_step(24'h800000, 24'h7fffff, 24'h000001, 16'h0001));
        send_word(make_step(24'h7fffff, 24'h800000, 24'hffffff, 16'h8000));
        send_word('{mode: 1'b1, vel_forward: 24'hffffff, vel_lateral: 24'hffffff,
                    yaw_rate: 24'hffffff, elapsed: 16'hffff});
        drain_poses();
        write_reg(poi_pkg::RegStartX, 32'h7fffffff);
        write_reg(poi_pkg::RegStartY, 32'h80000000);
        write_reg(poi_pkg::RegStartHeading, 32'hffffffff);
        send_word('{mode: 1'b1, default: '0});
        for (int i = 0; i < 8; i++)
            send_word(make_step(24'h7fffff, 24'h7fffff, 24'h200000, 16'hffff));
        drain_poses();
        // heading corners around quarter and half turns
        write_reg(poi_pkg::RegStartX, 32'h00000000);
        write_reg(poi_pkg::RegStartY, 32'h00000000);
        write_reg(poi_pkg::RegStartHeading, 32'h80000000);
        send_word('{mode: 1'b1, default: '0});
        send_word(make_step(24'h010000, 24'h0, 24'h0, 16'h1000));
        drain_poses();
        write_reg(poi_pkg::RegStartHeading, 32'hc0000001);
        send_word('{mode: 1'b1, default: '0});
        send_word(make_step(24'h010000, 24'h010000, 24'h0, 16'h1000));
        drain_poses();
    endtask

    task automatic test_random_phase(input int count, input logic [31:0] sx,
                                     input logic [31:0] sy, input logic [31:0] sh);
        write_reg(poi_pkg::RegStartX, sx);
        write_reg(poi_pkg::RegStartY, sy);
        write_reg(poi_pkg::RegStartHeading, sh);
        send_word('{mode: 1'b1, default: '0});
        for (int i = 0; i < count; i++) begin
            allow_stall = ($urandom_range(0, 3) != 0);
            send_word(random_word());
        end
        allow_stall = 1'b1;
        drain_poses();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++) send_word(random_word());
        drain_poses();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        error_count = 0;
        words_sent = 0;
        poses_checked = 0;
        reloads_sent = 0;
        clip_count = 0;
        hold_off = 1'b0;
        allow_stall = 1'b1;
        cfg_x = 32'sd524288;
        cfg_y = -32'sd131072;
        cfg_heading = 32'd0;
        pose_x = cfg_x;
        pose_y = cfg_y;
        pose_heading = cfg_heading;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(negedge i_clk);

        test_reset_pose();
        test_directed_extremes();
        test_backpressure();
        test_random_phase(350, $urandom, $urandom, $urandom);
        test_random_phase(350, 32'h0, 32'h0, 32'h0);
        test_random_phase(320, 32'h7ff00000, 32'h80100000, 32'h80000000);

        $display("sent %0d words (%0d reloads), checked %0d poses, %0d clipped",
                 words_sent, reloads_sent, poses_checked, clip_count);
        $display("covered register extremes, heading folds, saturation, long stalls");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ planar_odometry_integrator.f @@
design/poi_pkg.sv
design/poi_in_if.sv
design/poi_out_if.sv
design/poi_cordic.sv
design/poi_serial_mul.sv
design/planar_odometry_integrator.sv
tb/sv/planar_odometry_integrator_tb.sv
